@@ hdl/olsp_pkg.sv @@
// Shared types, codes and defaults for the oximeter line sample parser.
// Used by olsp_front, olsp_back, the top level and the checker; depends on nothing.
package olsp_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 1024;
   localparam int LINE_BYTES_DEFAULT  = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int TIME_WIDTH  = 20;
   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = 10;
   localparam int KIND_WIDTH  = 3;

   localparam logic [TIME_WIDTH-1:0] MIN_DURATION_RESET = 20'd16000;

   localparam logic [KIND_WIDTH-1:0] KIND_STORED       = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RESET        = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DROP_IGNORED = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_NOT_SAMPLE   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_FULL         = 3'd4;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [7:0] PREFIX_0 = 8'h55;
   localparam logic [7:0] PREFIX_1 = 8'h31;
   localparam logic [7:0] PREFIX_2 = 8'h3A;

   typedef struct packed {
      logic                  cmd;
      logic [7:0]            rx_byte;
      logic [TIME_WIDTH-1:0] elapsed_ms;
   } req_item_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]         line_kind;
      logic signed [VALUE_WIDTH-1:0] sample_value;
      logic [INDEX_WIDTH-1:0]        sample_index;
      logic [TIME_WIDTH-1:0]         timestamp_ms;
   } rsp_item_type;

   typedef struct packed {
      logic                  cmd;
      logic                  term;
      logic                  nul;
      logic                  blank;
      logic                  plus;
      logic                  minus;
      logic                  digit;
      logic [3:0]            digit_value;
      logic [2:0]            prefix_match;
      logic [TIME_WIDTH-1:0] elapsed_ms;
   } class_item_type;

endpackage

@@ hdl/olsp_fifo.sv @@
// Short first-in first-out queue of packed words.
// Generic; depends on nothing.
module olsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ hdl/olsp_front.sv @@
// Front end: classifies each received byte for the line parser.
// Depends on olsp_pkg.
module olsp_front (
   input  olsp_pkg::req_item_type   req_item,
   output olsp_pkg::class_item_type class_item
);

   logic [7:0] c;

   assign c = req_item.rx_byte;

   always_comb begin
      class_item.cmd   = req_item.cmd;
      class_item.term  = (c == olsp_pkg::CHAR_LF) || (c == olsp_pkg::CHAR_CR);
      class_item.nul   = (c == olsp_pkg::CHAR_NUL);
      class_item.blank = (c == olsp_pkg::CHAR_SPACE) || (c == olsp_pkg::CHAR_TAB) ||
                         (c == olsp_pkg::CHAR_VT) || (c == olsp_pkg::CHAR_FF);
      class_item.plus  = (c == olsp_pkg::CHAR_PLUS);
      class_item.minus = (c == olsp_pkg::CHAR_MINUS);
      class_item.digit = (c >= olsp_pkg::CHAR_ZERO) && (c <= olsp_pkg::CHAR_NINE);
      class_item.digit_value     = c[3:0];
      class_item.prefix_match[0] = (c == olsp_pkg::PREFIX_0);
      class_item.prefix_match[1] = (c == olsp_pkg::PREFIX_1);
      class_item.prefix_match[2] = (c == olsp_pkg::PREFIX_2);
      class_item.elapsed_ms      = req_item.elapsed_ms;
   end

endmodule

@@ hdl/olsp_back.sv @@
// Back end: line state, atol-style number accumulation and sample decision.
// Holds the duration register. Depends on olsp_pkg.
module olsp_back #(
   parameter int MAX_SAMPLES = olsp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int LINE_BYTES  = olsp_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  olsp_pkg::class_item_type        q_item,
   output logic                            q_pop,
   input  logic                            out_full,
   output logic                            out_push,
   output olsp_pkg::rsp_item_type          out_item,
   input  logic                            csr_valid,
   input  logic [olsp_pkg::TIME_WIDTH-1:0] csr_data
);

   localparam int LW = $clog2(LINE_BYTES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   logic [olsp_pkg::TIME_WIDTH-1:0] min_dur_ff;
   logic [LW-1:0] line_len_ff, line_len_in;
   logic [1:0]    progress_ff, progress_in;
   logic          failed_ff, failed_in;
   phase_type     phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic [31:0]   mag_ff, mag_in;
   logic [1:0]    tail_ff, tail_in;
   logic          ended_ff, ended_in;
   logic [CW-1:0] count_ff, count_in;

   logic          fire;
   logic [35:0]   mag_next;
   logic [31:0]   value;
   logic          clear;

   assign fire  = !q_empty && !out_full;
   assign q_pop = fire;

   assign mag_next = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) +
                     {32'd0, q_item.digit_value};

   always_comb begin
      if (neg_ff) begin
         value = (mag_ff >= MAG_LIMIT) ? MAG_LIMIT : (32'd0 - mag_ff);
      end else begin
         value = (mag_ff >= MAG_LIMIT) ? POS_MAX : mag_ff;
      end
   end

   always_comb begin
      line_len_in = line_len_ff;
      progress_in = progress_ff;
      failed_in   = failed_ff;
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      tail_in     = tail_ff;
      ended_in    = ended_ff;
      count_in    = count_ff;
      clear       = 1'b0;
      out_push    = 1'b0;
      out_item.line_kind    = olsp_pkg::KIND_NOT_SAMPLE;
      out_item.sample_value = '0;
      out_item.sample_index = '0;
      out_item.timestamp_ms = q_item.elapsed_ms;

      if (fire) begin
         if (q_item.cmd) begin
            count_in = '0;
            clear    = 1'b1;
         end else if (!q_item.term) begin
            if (line_len_ff < LW'(LINE_BYTES - 1)) begin
               line_len_in = line_len_ff + 1'b1;
               if (progress_ff != 2'd3) begin
                  if (!q_item.prefix_match[progress_ff]) begin
                     failed_in = 1'b1;
                  end
                  progress_in = progress_ff + 1'b1;
               end else if (!failed_ff && !ended_ff) begin
                  if (q_item.nul) begin
                     ended_in = 1'b1;
                  end else begin
                     if (tail_ff != 2'd3) begin
                        tail_in = tail_ff + 1'b1;
                     end
                     if (phase_ff == PH_SKIP && q_item.blank) begin
                        phase_in = PH_SKIP;
                     end else if (phase_ff == PH_SKIP && q_item.plus) begin
                        phase_in = PH_SIGN;
                     end else if (phase_ff == PH_SKIP && q_item.minus) begin
                        neg_in   = 1'b1;
                        phase_in = PH_SIGN;
                     end else if (phase_ff != PH_DONE && q_item.digit) begin
                        mag_in   = (mag_next > {4'd0, MAG_LIMIT}) ? MAG_LIMIT
                                                                   : mag_next[31:0];
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
         end else if (line_len_ff != '0) begin
            out_push = 1'b1;
            clear    = 1'b1;
            if (failed_ff || progress_ff != 2'd3) begin
               out_item.line_kind = olsp_pkg::KIND_NOT_SAMPLE;
            end else begin
               out_item.sample_value = $signed(value);
               if (value == '0 && tail_ff != 2'd3) begin
                  if (q_item.elapsed_ms >= min_dur_ff) begin
                     out_item.line_kind = olsp_pkg::KIND_DROP_IGNORED;
                  end else begin
                     out_item.line_kind = olsp_pkg::KIND_RESET;
                     count_in           = '0;
                  end
               end else if (count_ff < CW'(MAX_SAMPLES)) begin
                  out_item.line_kind    = olsp_pkg::KIND_STORED;
                  out_item.sample_index = olsp_pkg::INDEX_WIDTH'(count_ff);
                  count_in              = count_ff + 1'b1;
               end else begin
                  out_item.line_kind = olsp_pkg::KIND_FULL;
               end
            end
         end
      end

      if (clear) begin
         line_len_in = '0;
         progress_in = '0;
         failed_in   = 1'b0;
         phase_in    = PH_SKIP;
         neg_in      = 1'b0;
         mag_in      = '0;
         tail_in     = '0;
         ended_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff  <= olsp_pkg::MIN_DURATION_RESET;
         line_len_ff <= '0;
         progress_ff <= '0;
         failed_ff   <= 1'b0;
         phase_ff    <= PH_SKIP;
         neg_ff      <= 1'b0;
         mag_ff      <= '0;
         tail_ff     <= '0;
         ended_ff    <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (csr_valid) begin
            min_dur_ff <= csr_data;
         end
         line_len_ff <= line_len_in;
         progress_ff <= progress_in;
         failed_ff   <= failed_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         mag_ff      <= mag_in;
         tail_ff     <= tail_in;
         ended_ff    <= ended_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ hdl/oximeter_line_sample_parser_top.sv @@
// Oximeter line sample parser: takes one serial byte per cycle while req_full is low,
// frames lines on CR or LF, parses "U1:" sample lines and reports one result per completed
// non-empty line. The front end classifies each byte into a short queue; the back end pops
// the queue, updates the line state for each byte and writes results into an output queue,
// which drives the result ports. Sustained rate is one byte per cycle while neither queue is
// full; the multiply-by-ten accumulate in the back end uses shifts and adds. The duration
// register port is always ready. No clearing pass is needed after reset.
// Depends on olsp_pkg, olsp_front, olsp_fifo and olsp_back.
module oximeter_line_sample_parser_top #(
   parameter int MAX_SAMPLES = olsp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int LINE_BYTES  = olsp_pkg::LINE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = olsp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  olsp_pkg::req_item_type          req_item,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output olsp_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [olsp_pkg::TIME_WIDTH-1:0] csr_data
);

   localparam int CLASS_W = $bits(olsp_pkg::class_item_type);
   localparam int RSP_W   = $bits(olsp_pkg::rsp_item_type);

   olsp_pkg::class_item_type class_item, q_item;
   olsp_pkg::rsp_item_type   back_item;
   logic q_empty, q_pop, out_full, out_push;

   assign csr_ready = 1'b1;

   olsp_front u_front (
      .req_item   (req_item),
      .class_item (class_item)
   );

   olsp_fifo #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_class_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (class_item),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_item)
   );

   olsp_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .LINE_BYTES  (LINE_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (back_item),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

   olsp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .wdata (back_item),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_item)
   );

endmodule

@@ hdl/olsp_checker.sv @@
// Port-level checks for the oximeter line sample parser, bound to the top level.
// Depends on olsp_pkg and oximeter_line_sample_parser_top.
module olsp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input olsp_pkg::rsp_item_type rsp_item
);

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_item))
      else $error("waiting result changed");

   a_index_only_stored: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_item.line_kind != olsp_pkg::KIND_STORED
      |-> rsp_item.sample_index == '0)
      else $error("index on a result that was not stored");

   a_not_sample_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_item.line_kind == olsp_pkg::KIND_NOT_SAMPLE
      |-> rsp_item.sample_value == '0)
      else $error("value on a line that is not a sample line");

endmodule

bind oximeter_line_sample_parser_top olsp_checker u_olsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);
